@@ rtl/cfb_pkg.sv @@
// ----------------------------------------------------------------------------
// cfb_pkg
// Types, constants and arithmetic helpers shared by the comb bank modules.
// ----------------------------------------------------------------------------
package cfb_pkg;

   localparam int SampleW = 16;
   localparam int GainW   = 17;
   localparam int MulW    = 18;
   localparam int ProdW   = 36;
   localparam int LpW     = 32;
   localparam int CountW  = 3;
   localparam int MaskW   = 4;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 16;

   localparam logic [GainW-1:0] Unity  = 17'd32768;
   localparam logic [31:0]      Recip3 = 32'hAAAA_AAAB;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ACTIVE_MASK   = 3'd0,
      CSR_DELAY_SAMPLES = 3'd1,
      CSR_FEEDBACK_GAIN = 3'd2,
      CSR_COMB_LEVEL    = 3'd3,
      CSR_LP_B0         = 3'd4,
      CSR_LP_B1         = 3'd5,
      CSR_LP_A1         = 3'd6,
      CSR_WET_LEVEL     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [MaskW-1:0]          active_mask;
      logic [10:0]               delay_samples;
      logic [15:0]               feedback_gain;
      logic [15:0]               comb_level;
      logic signed [15:0]        lp_b0;
      logic signed [15:0]        lp_b1;
      logic signed [15:0]        lp_a1;
      logic [15:0]               wet_level;
   } cfg_type;

   function automatic logic [GainW-1:0] unity_clamp(input logic [15:0] g);
      return (g > 16'd32768) ? Unity : {1'b0, g};
   endfunction

   // Round to nearest with ties upwards, then drop 15 fraction bits.
   function automatic logic signed [ProdW-1:0] round_q15(input logic signed [ProdW-1:0] v);
      return (v + 36'sd16384) >>> 15;
   endfunction

   function automatic logic signed [SampleW-1:0] sat16(input logic signed [ProdW-1:0] v);
      if (v > 36'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -36'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic logic signed [LpW-1:0] sat32(input logic signed [ProdW-1:0] v);
      if (v > 36'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // tanh sampled every 0.125 over 0..4.0, Q1.15.
   function automatic logic [15:0] tanh_tab(input logic [5:0] idx);
      logic [15:0] t;
      case (idx)
         6'd0:  t = 16'd0;
         6'd1:  t = 16'd4075;
         6'd2:  t = 16'd8026;
         6'd3:  t = 16'd11743;
         6'd4:  t = 16'd15143;
         6'd5:  t = 16'd18173;
         6'd6:  t = 16'd20813;
         6'd7:  t = 16'd23073;
         6'd8:  t = 16'd24956;
         6'd9:  t = 16'd26519;
         6'd10: t = 16'd27797;
         6'd11: t = 16'd28831;
         6'd12: t = 16'd29660;
         6'd13: t = 16'd30322;
         6'd14: t = 16'd30847;
         6'd15: t = 16'd31262;
         6'd16: t = 16'd31589;
         6'd17: t = 16'd31847;
         6'd18: t = 16'd32048;
         6'd19: t = 16'd32207;
         6'd20: t = 16'd32329;
         6'd21: t = 16'd32425;
         6'd22: t = 16'd32500;
         6'd23: t = 16'd32558;
         6'd24: t = 16'd32606;
         6'd25: t = 16'd32642;
         6'd26: t = 16'd32670;
         6'd27: t = 16'd32692;
         6'd28: t = 16'd32708;
         6'd29: t = 16'd32722;
         6'd30: t = 16'd32732;
         6'd31: t = 16'd32740;
         6'd32: t = 16'd32746;
         default: t = 16'd0;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/cfb_delay_ram.sv @@
// ----------------------------------------------------------------------------
// cfb_delay_ram
// Delay line storage for all combs: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfb_delay_ram #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cfb_line_ram.sv @@
// ----------------------------------------------------------------------------
// cfb_line_ram
// Per-line state (wrap flag, write position, lowpass state) with a valid bit
// per entry so that an entry not yet written reads as zero after reset.
// ----------------------------------------------------------------------------
module cfb_line_ram #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3,
   parameter int DATA_W = 43
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

@@ rtl/cfb_engine.sv @@
// ----------------------------------------------------------------------------
// cfb_engine
// Sequencer and shared arithmetic: walks the combs of one channel, reads and
// writes back their line state and delay lines, then averages and mixes.
// ----------------------------------------------------------------------------
module cfb_engine #(
   parameter int NUM_COMBS    = 4,
   parameter int MAX_DELAY    = 1024,
   parameter int NUM_CHANNELS = 2,
   localparam int NumLines = NUM_COMBS * NUM_CHANNELS,
   localparam int LineW    = (NumLines > 1) ? $clog2(NumLines) : 1,
   localparam int AddrW    = $clog2(MAX_DELAY),
   localparam int EntryW   = 1 + AddrW + 32,
   localparam int DlyAddrW = LineW + AddrW
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfb_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_channel,
   input  logic signed [15:0]          req_in_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [15:0]          rsp_out_sample,
   output logic                        line_re,
   output logic [LineW-1:0]            line_raddr,
   input  logic [EntryW-1:0]           line_rdata,
   output logic                        line_we,
   output logic [LineW-1:0]            line_waddr,
   output logic [EntryW-1:0]           line_wdata,
   output logic                        dly_re,
   output logic [DlyAddrW-1:0]         dly_raddr,
   input  logic [15:0]                 dly_rdata,
   output logic                        dly_we,
   output logic [DlyAddrW-1:0]         dly_waddr,
   output logic [15:0]                 dly_wdata
);

   import cfb_pkg::*;

   localparam int CombW = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
   localparam logic [AddrW:0]   MaxD     = (AddrW + 1)'(MAX_DELAY);
   localparam logic [CombW-1:0] LastComb = CombW'(NUM_COMBS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LREAD, ST_DREAD, ST_MB0, ST_MB1, ST_MA1, ST_MFB, ST_MLV,
      ST_MTH, ST_WR, ST_DIV, ST_QUO, ST_MIX1, ST_MIX2
   } state_type;

   state_type                 state_ff;
   logic [CombW-1:0]          comb_ff;
   logic [CountW-1:0]         count_ff;
   logic                      ch_ff;
   logic signed [15:0]        x_ff;
   logic                      wrapped_ff;
   logic [AddrW-1:0]          wp_ff;
   logic signed [LpW-1:0]     lps_ff;
   logic                      hit_ff;
   logic signed [15:0]        xd_ff;
   logic signed [15:0]        y_ff;
   logic signed [ProdW-1:0]   b1x_ff;
   logic signed [LpW-1:0]     lps_new_ff;
   logic [17:0]               a_ff;
   logic                      neg_ff;
   logic                      big_ff;
   logic signed [ProdW-1:0]   sum_ff;
   logic [ProdW-1:0]          mag_ff;
   logic                      sum_neg_ff;
   logic [63:0]               recip_ff;
   logic signed [15:0]        wet_ff;
   logic signed [ProdW-1:0]   dry_ff;
   logic                      rsp_valid_ff;
   logic signed [15:0]        rsp_out_ff;
   logic signed [ProdW-1:0]   prod_ff;

   logic [NUM_COMBS-1:0]      comb_en;
   logic                      ch_eff;
   logic [LineW-1:0]          line_cur;
   logic [GainW-1:0]          fb_g, lvl_g, wet_g, dry_g;
   logic [17:0]               d_wide;
   logic [AddrW:0]            d_eff;
   logic                      rd_wrapped;
   logic [AddrW-1:0]          rd_wp;
   logic [AddrW+1:0]          rd_sum;
   logic [AddrW-1:0]          rd_pos;
   logic signed [15:0]        xd_now;
   logic signed [MulW-1:0]    mul_a, mul_b;
   logic signed [ProdW-1:0]   y_in;
   logic signed [ProdW-1:0]   v_in;
   logic [ProdW-1:0]          abs_v;
   logic [4:0]                tab_idx;
   logic [15:0]               tab_base;
   logic [15:0]               tab_diff;
   logic [15:0]               tanh_mag;
   logic signed [15:0]        tanh_in;
   logic                      wp_last;
   logic [AddrW-1:0]          wp_next;
   logic [ProdW-1:0]          sum_abs;
   logic [ProdW-1:0]          q_mag;
   logic signed [ProdW-1:0]   q_in;
   logic signed [15:0]        wet_in;
   logic signed [15:0]        mix_in;

   for (genvar c = 0; c < NUM_COMBS; c++) begin : g_en
      if (c < MaskW) begin : g_bit
         assign comb_en[c] = cfg.active_mask[c];
      end else begin : g_none
         assign comb_en[c] = 1'b0;
      end
   end

   assign ch_eff   = (NUM_CHANNELS > 1) ? ch_ff : 1'b0;
   assign line_cur = LineW'(int'(comb_ff) * NUM_CHANNELS + int'(ch_eff));

   assign fb_g  = unity_clamp(cfg.feedback_gain);
   assign lvl_g = unity_clamp(cfg.comb_level);
   assign wet_g = unity_clamp(cfg.wet_level);
   assign dry_g = Unity - wet_g;

   // Delay length limited to 1..MAX_DELAY.
   assign d_wide = {7'd0, cfg.delay_samples};
   always_comb begin
      if (d_wide == 18'd0) begin
         d_eff = (AddrW + 1)'(1);
      end else if (d_wide > 18'(MAX_DELAY)) begin
         d_eff = MaxD;
      end else begin
         d_eff = d_wide[AddrW:0];
      end
   end

   // Read position behind the write position, and whether that entry was
   // ever written since reset: entries fill in order, so a line that has not
   // wrapped holds data only below its write position.
   assign rd_wrapped = line_rdata[EntryW-1];
   assign rd_wp      = line_rdata[EntryW-2 -: AddrW];
   assign rd_sum     = {2'b00, rd_wp} + {1'b0, MaxD} - {1'b0, d_eff};
   always_comb begin
      if (rd_sum >= {1'b0, MaxD}) begin
         rd_pos = AddrW'(rd_sum - {1'b0, MaxD});
      end else begin
         rd_pos = rd_sum[AddrW-1:0];
      end
   end

   assign xd_now = hit_ff ? signed'(dly_rdata) : 16'sd0;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MB0: begin
            mul_a = MulW'(cfg.lp_b0);
            mul_b = MulW'(xd_now);
         end
         ST_MB1: begin
            mul_a = MulW'(cfg.lp_b1);
            mul_b = MulW'(xd_ff);
         end
         ST_MA1: begin
            mul_a = MulW'(cfg.lp_a1);
            mul_b = MulW'(y_ff);
         end
         ST_MFB: begin
            mul_a = signed'({1'b0, fb_g});
            mul_b = MulW'(y_ff);
         end
         ST_MLV: begin
            mul_a = MulW'(y_ff);
            mul_b = signed'({1'b0, lvl_g});
         end
         ST_MTH: begin
            mul_a = signed'({2'b00, tab_diff});
            mul_b = signed'({6'd0, a_ff[11:0]});
         end
         ST_QUO: begin
            mul_a = MulW'(x_ff);
            mul_b = signed'({1'b0, dry_g});
         end
         ST_MIX1, ST_MIX2: begin
            mul_a = MulW'(wet_ff);
            mul_b = signed'({1'b0, wet_g});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Lowpass output from b0*xd plus the stored state.
   assign y_in = round_q15(prod_ff + ProdW'(lps_ff));

   // Feedback sum ahead of the tanh bound.
   assign v_in  = round_q15((ProdW'(x_ff) <<< 15) + prod_ff);
   assign abs_v = v_in[ProdW-1] ? ProdW'(-v_in) : ProdW'(v_in);

   assign tab_idx  = a_ff[16:12];
   assign tab_base = tanh_tab({1'b0, tab_idx});
   assign tab_diff = tanh_tab(6'({1'b0, tab_idx} + 6'd1)) - tab_base;

   always_comb begin
      if (big_ff) begin
         tanh_mag = tanh_tab(6'd32);
      end else begin
         tanh_mag = tab_base + 16'((prod_ff + 36'sd2048) >>> 12);
      end
      tanh_in = neg_ff ? -signed'(tanh_mag) : signed'(tanh_mag);
   end

   assign wp_last = ({1'b0, wp_ff} == MaxD - (AddrW + 1)'(1));
   assign wp_next = wp_last ? '0 : AddrW'(wp_ff + 1'b1);

   // Average over the active combs: the count is at most four, so only a
   // count of three needs the reciprocal product.
   assign sum_abs = sum_ff[ProdW-1] ? ProdW'(-sum_ff) : ProdW'(sum_ff);
   always_comb begin
      case (count_ff)
         3'd1:    q_mag = mag_ff;
         3'd2:    q_mag = mag_ff >> 1;
         3'd3:    q_mag = ProdW'(recip_ff[63:33]);
         3'd4:    q_mag = mag_ff >> 2;
         default: q_mag = mag_ff;
      endcase
      q_in = sum_neg_ff ? -signed'(q_mag) : signed'(q_mag);
      if (count_ff == '0) begin
         wet_in = 16'sd0;
      end else begin
         wet_in = sat16(round_q15(q_in));
      end
   end

   assign mix_in = sat16(round_q15(dry_ff + prod_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         comb_ff      <= '0;
         count_ff     <= '0;
      end else begin
         // The final mix step decides the output register on its own.
         if (rsp_ready && (state_ff != ST_MIX2)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  ch_ff    <= req_channel;
                  x_ff     <= req_in_sample;
                  comb_ff  <= '0;
                  count_ff <= '0;
                  sum_ff   <= '0;
                  state_ff <= ST_LREAD;
               end
            end
            ST_LREAD: begin
               if (comb_en[comb_ff]) begin
                  count_ff <= CountW'(count_ff + 1'b1);
                  state_ff <= ST_DREAD;
               end else if (comb_ff == LastComb) begin
                  state_ff <= ST_DIV;
               end else begin
                  comb_ff <= CombW'(comb_ff + 1'b1);
               end
            end
            ST_DREAD: begin
               wrapped_ff <= rd_wrapped;
               wp_ff      <= rd_wp;
               lps_ff     <= signed'(line_rdata[LpW-1:0]);
               hit_ff     <= rd_wrapped || (rd_pos < rd_wp);
               state_ff   <= ST_MB0;
            end
            ST_MB0: begin
               xd_ff    <= xd_now;
               state_ff <= ST_MB1;
            end
            ST_MB1: begin
               y_ff     <= sat16(y_in);
               state_ff <= ST_MA1;
            end
            ST_MA1: begin
               b1x_ff   <= prod_ff;
               state_ff <= ST_MFB;
            end
            ST_MFB: begin
               lps_new_ff <= sat32(b1x_ff - prod_ff);
               state_ff   <= ST_MLV;
            end
            ST_MLV: begin
               a_ff     <= abs_v[17:0];
               big_ff   <= (abs_v >= 36'd131072);
               neg_ff   <= v_in[ProdW-1];
               state_ff <= ST_MTH;
            end
            ST_MTH: begin
               sum_ff   <= sum_ff + prod_ff;
               state_ff <= ST_WR;
            end
            ST_WR: begin
               if (comb_ff == LastComb) begin
                  state_ff <= ST_DIV;
               end else begin
                  comb_ff  <= CombW'(comb_ff + 1'b1);
                  state_ff <= ST_LREAD;
               end
            end
            ST_DIV: begin
               mag_ff     <= sum_abs;
               sum_neg_ff <= sum_ff[ProdW-1];
               recip_ff   <= sum_abs[31:0] * Recip3;
               state_ff   <= ST_QUO;
            end
            ST_QUO: begin
               wet_ff   <= wet_in;
               state_ff <= ST_MIX1;
            end
            ST_MIX1: begin
               dry_ff   <= prod_ff;
               state_ff <= ST_MIX2;
            end
            ST_MIX2: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_out_ff   <= mix_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_ff;

   // Each line a request uses is read once and written back once, and the
   // write-back lands before the next line read, so no forwarding is needed.
   assign line_re    = (state_ff == ST_LREAD) && comb_en[comb_ff];
   assign line_raddr = line_cur;
   assign line_we    = (state_ff == ST_WR);
   assign line_waddr = line_cur;
   assign line_wdata = {wrapped_ff | wp_last, wp_next, lps_new_ff};

   assign dly_re    = (state_ff == ST_DREAD);
   assign dly_raddr = {line_cur, rd_pos};
   assign dly_we    = (state_ff == ST_WR);
   assign dly_waddr = {line_cur, wp_ff};
   assign dly_wdata = tanh_in;

endmodule

@@ rtl/damped_feedback_comb_bank.sv @@
// ----------------------------------------------------------------------------
// damped_feedback_comb_bank
// Stereo bank of lowpass-damped feedback combs with tanh bounding and a
// dry/wet mix.
// ----------------------------------------------------------------------------
// Usage: each request carries one Q1.15 sample and its channel on req_*; the
// response on rsp_* carries the mixed sample, one response per request, in
// order. Settings are written through csr_wr_en, csr_index and csr_wr_data;
// the user must write them only while the block is idle, which the block
// does not enforce. A write takes effect at once. The engine runs one
// request at a time and takes the next only when it is back in idle. Each
// request steps through every comb slot of its channel in turn, then
// averages and mixes. Each active comb costs a line state read, a delay
// read and six steps of the shared 18x18 multiplier.
// The response sits in an output register: a new request is accepted while
// it waits, and the engine holds its finished result until rsp_ready frees
// the register. Reset loads the default settings, empties all write
// positions and lowpass states and marks every delay line as unwritten,
// which reads as silence; no clearing pass is needed.
// ----------------------------------------------------------------------------
module damped_feedback_comb_bank #(
   parameter int NUM_COMBS    = 4,
   parameter int MAX_DELAY    = 1024,
   parameter int NUM_CHANNELS = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_channel,
   input  logic signed [15:0]              req_in_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [15:0]              rsp_out_sample,
   input  logic                            csr_wr_en,
   input  logic [cfb_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [cfb_pkg::CsrW-1:0]        csr_wr_data
);

   import cfb_pkg::*;

   localparam int NumLines = NUM_COMBS * NUM_CHANNELS;
   localparam int LineW    = (NumLines > 1) ? $clog2(NumLines) : 1;
   localparam int AddrW    = $clog2(MAX_DELAY);
   localparam int EntryW   = 1 + AddrW + 32;
   localparam int DlyAddrW = LineW + AddrW;

   cfg_type               cfg_ff;
   logic                  line_re, line_we;
   logic [LineW-1:0]      line_raddr, line_waddr;
   logic [EntryW-1:0]     line_rdata, line_wdata;
   logic                  dly_re, dly_we;
   logic [DlyAddrW-1:0]   dly_raddr, dly_waddr;
   logic [15:0]           dly_rdata, dly_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_mask   <= 4'd0;
         cfg_ff.delay_samples <= 11'd1024;
         cfg_ff.feedback_gain <= 16'd16384;
         cfg_ff.comb_level    <= 16'd8192;
         cfg_ff.lp_b0         <= 16'sd2188;
         cfg_ff.lp_b1         <= 16'sd2188;
         cfg_ff.lp_a1         <= -16'sd28392;
         cfg_ff.wet_level     <= 16'd16384;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ACTIVE_MASK:   cfg_ff.active_mask   <= csr_wr_data[MaskW-1:0];
            CSR_DELAY_SAMPLES: cfg_ff.delay_samples <= csr_wr_data[10:0];
            CSR_FEEDBACK_GAIN: cfg_ff.feedback_gain <= csr_wr_data;
            CSR_COMB_LEVEL:    cfg_ff.comb_level    <= csr_wr_data;
            CSR_LP_B0:         cfg_ff.lp_b0         <= signed'(csr_wr_data);
            CSR_LP_B1:         cfg_ff.lp_b1         <= signed'(csr_wr_data);
            CSR_LP_A1:         cfg_ff.lp_a1         <= signed'(csr_wr_data);
            CSR_WET_LEVEL:     cfg_ff.wet_level     <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   cfb_engine #(
      .NUM_COMBS    (NUM_COMBS),
      .MAX_DELAY    (MAX_DELAY),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_channel    (req_channel),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .line_re        (line_re),
      .line_raddr     (line_raddr),
      .line_rdata     (line_rdata),
      .line_we        (line_we),
      .line_waddr     (line_waddr),
      .line_wdata     (line_wdata),
      .dly_re         (dly_re),
      .dly_raddr      (dly_raddr),
      .dly_rdata      (dly_rdata),
      .dly_we         (dly_we),
      .dly_waddr      (dly_waddr),
      .dly_wdata      (dly_wdata)
   );

   cfb_line_ram #(
      .DEPTH  (NumLines),
      .ADDR_W (LineW),
      .DATA_W (EntryW)
   ) u_line_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (line_re),
      .rd_addr (line_raddr),
      .rd_data (line_rdata),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata)
   );

   cfb_delay_ram #(
      .ADDR_W (DlyAddrW),
      .DATA_W (16)
   ) u_delay_ram (
      .clock   (clock),
      .rd_en   (dly_re),
      .rd_addr (dly_raddr),
      .rd_data (dly_rdata),
      .wr_en   (dly_we),
      .wr_addr (dly_waddr),
      .wr_data (dly_wdata)
   );

   // A comb's delay sample and its line state are always written back together.
   a_writeback_pair : assert property (@(posedge clock) disable iff (reset)
      line_we == dly_we)
      else $error("delay line and line state written back apart");

   // The line state port is never read and written in the same cycle.
   a_line_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(line_re && line_we))
      else $error("line state read and write overlap");

   // No memory is touched while the block waits for a request.
   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!line_we && !dly_we && !dly_re))
      else $error("memory access while idle");

   // A taken request keeps the engine busy for at least the next cycle.
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one is in progress");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the damped feedback comb bank. A scoreboard class
// keeps its own model of the comb lines, lowpass states and settings, works
// out the mixed sample for every request taken and compares it with each
// response in order. Directed requests cover the extremes and the special
// settings; random phases then vary the settings and the traffic pattern.
// ----------------------------------------------------------------------------
module testbench;
   import cfb_pkg::*;

   localparam int RandomPhases   = 12;
   localparam int ItemsPerPhase  = 71;
   localparam int StallLimit     = 4000;
   localparam int SettleCycles   = 64;

   class comb_scoreboard;
      localparam int NumCombs    = 4;
      localparam int MaxDelay    = 1024;
      localparam int NumChannels = 2;
      localparam int NumLanes    = NumCombs * NumChannels;

      logic [3:0]         active_mask;
      logic [10:0]        delay_samples;
      logic [15:0]        feedback_gain;
      logic [15:0]        comb_level;
      logic [15:0]        wet_level;
      logic signed [15:0] lp_b0;
      logic signed [15:0] lp_b1;
      logic signed [15:0] lp_a1;

      logic signed [15:0] line_store [NumLanes][MaxDelay];
      int                 write_pos [NumLanes];
      longint             lp_state [NumLanes];
      int                 tanh_points [33];

      logic signed [15:0] expected_q [$];
      int                 failures;

      function new();
         tanh_points = '{0, 4075, 8026, 11743, 15143, 18173, 20813, 23073,
                         24956, 26519, 27797, 28831, 29660, 30322, 30847, 31262,
                         31589, 31847, 32048, 32207, 32329, 32425, 32500, 32558,
                         32606, 32642, 32670, 32692, 32708, 32722, 32732, 32740,
                         32746};
         active_mask   = 4'd0;
         delay_samples = 11'd1024;
         feedback_gain = 16'd16384;
         comb_level    = 16'd8192;
         lp_b0         = 16'sd2188;
         lp_b1         = 16'sd2188;
         lp_a1         = -16'sd28392;
         wet_level     = 16'd16384;
         for (int l = 0; l < NumLanes; l++) begin
            write_pos[l] = 0;
            lp_state[l]  = 0;
            for (int k = 0; k < MaxDelay; k++) begin
               line_store[l][k] = '0;
            end
         end
         failures = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_ACTIVE_MASK:   active_mask   = data[3:0];
            CSR_DELAY_SAMPLES: delay_samples = data[10:0];
            CSR_FEEDBACK_GAIN: feedback_gain = data;
            CSR_COMB_LEVEL:    comb_level    = data;
            CSR_LP_B0:         lp_b0         = data;
            CSR_LP_B1:         lp_b1         = data;
            CSR_LP_A1:         lp_a1         = data;
            CSR_WET_LEVEL:     wet_level     = data;
            default: ;
         endcase
      endfunction

      // Round to nearest with ties upwards, then drop s fraction bits.
      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function longint gain_of(logic [15:0] g);
         return (g > 16'd32768) ? 32768 : longint'(g);
      endfunction

      function longint bounded_tanh(longint v);
         longint mag;
         longint y;
         longint f;
         int     i;
         mag = (v < 0) ? -v : v;
         if (mag >= 131072) begin
            y = tanh_points[32];
         end else begin
            i = int'(mag >>> 12);
            f = mag & 4095;
            y = tanh_points[i]
                + round_shift(longint'(tanh_points[i + 1] - tanh_points[i]) * f, 12);
         end
         return (v < 0) ? -y : y;
      endfunction

      // Runs every enabled comb of the channel once and returns the mix.
      function logic signed [15:0] mix_sample(logic ch, logic signed [15:0] smp);
         int     d;
         int     lane;
         int     wp;
         int     rd;
         int     count;
         int     c;
         longint x, fb, lvl, w, b0, b1, a1;
         longint xd, y, v, sum, wet, res;
         x     = smp;
         fb    = gain_of(feedback_gain);
         lvl   = gain_of(comb_level);
         w     = gain_of(wet_level);
         b0    = lp_b0;
         b1    = lp_b1;
         a1    = lp_a1;
         sum   = 0;
         wet   = 0;
         count = 0;
         d     = int'(delay_samples);
         if (d < 1) d = 1;
         if (d > MaxDelay) d = MaxDelay;
         for (c = 0; c < NumCombs; c++) begin
            if (active_mask[c]) begin
               count++;
               lane = c * NumChannels + int'(ch);
               wp   = write_pos[lane];
               rd   = wp + MaxDelay - d;
               if (rd >= MaxDelay) rd -= MaxDelay;
               xd = line_store[lane][rd];
               y  = clip(round_shift(b0 * xd + lp_state[lane], 15), -32768, 32767);
               lp_state[lane] = clip(b1 * xd - a1 * y, longint'(32'sh8000_0000),
                                     longint'(32'sh7FFF_FFFF));
               v = round_shift(x * 32768 + fb * y, 15);
               line_store[lane][wp] = 16'(bounded_tanh(v));
               write_pos[lane] = (wp + 1 == MaxDelay) ? 0 : wp + 1;
               sum += y * lvl;
            end
         end
         if (count > 0) begin
            wet = clip(round_shift(sum / count, 15), -32768, 32767);
         end
         res = clip(round_shift(x * (32768 - w) + wet * w, 15), -32768, 32767);
         return res[15:0];
      endfunction

      function void note_request(logic ch, logic signed [15:0] smp);
         expected_q.push_back(mix_sample(ch, smp));
      endfunction

      function void check_response(logic signed [15:0] actual);
         logic signed [15:0] exp_sample;
         if (expected_q.size() == 0) begin
            $error("out_sample: response with no request outstanding, actual %0d", actual);
            failures++;
         end else begin
            exp_sample = expected_q.pop_front();
            if (actual !== exp_sample) begin
               $error("out_sample mismatch: expected %0d, actual %0d", exp_sample, actual);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_channel = 1'b0;
   logic signed [15:0] req_in_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_sample;
   logic               csr_wr_en = 1'b0;
   csr_index_type      csr_index = CSR_ACTIVE_MASK;
   logic [CsrW-1:0]    csr_wr_data = '0;

   int                 sender_idle_pct = 17;
   int                 receiver_idle_pct = 67;
   int                 stall_cycles = 0;
   comb_scoreboard     scoreboard = new();

   damped_feedback_comb_bank i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_channel    (req_channel),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            scoreboard.note_request(req_channel, req_in_sample);
         end
         if (rsp_valid && rsp_ready) begin
            scoreboard.check_response(rsp_out_sample);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (stall_cycles >= StallLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_request(input logic ch, input logic signed [15:0] smp);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_channel   <= ch;
      req_in_sample <= smp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drops valid and waits until every request has had its response.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      scoreboard.write_register(idx, data);
   endtask

   task automatic apply_settings(input cfg_type s);
      write_csr(CSR_ACTIVE_MASK, {12'd0, s.active_mask});
      write_csr(CSR_DELAY_SAMPLES, {5'd0, s.delay_samples});
      write_csr(CSR_FEEDBACK_GAIN, s.feedback_gain);
      write_csr(CSR_COMB_LEVEL, s.comb_level);
      write_csr(CSR_LP_B0, s.lp_b0);
      write_csr(CSR_LP_B1, s.lp_b1);
      write_csr(CSR_LP_A1, s.lp_a1);
      write_csr(CSR_WET_LEVEL, s.wet_level);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(9))
         6:       return 16'd32768;
         7:       return 16'd0;
         8:       return 16'($urandom_range(65535, 32769));
         9:       return 16'($urandom);
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      s.active_mask = 4'($urandom_range(15));
      case ($urandom_range(9))
         6:       s.delay_samples = 11'd0;
         7:       s.delay_samples = 11'd1024;
         8:       s.delay_samples = 11'($urandom_range(2047, 1025));
         9:       s.delay_samples = 11'($urandom_range(1024, 49));
         default: s.delay_samples = 11'($urandom_range(48, 1));
      endcase
      s.feedback_gain = pick_gain();
      s.comb_level    = pick_gain();
      s.wet_level     = pick_gain();
      // Half the phases use a damped lowpass, the rest any coefficients.
      if ($urandom_range(1) == 0) begin
         s.lp_b0 = 16'($urandom_range(8000));
         s.lp_b1 = 16'($urandom_range(8000));
         s.lp_a1 = 16'(-int'($urandom_range(32768, 16000)));
      end else begin
         s.lp_b0 = 16'($urandom);
         s.lp_b1 = 16'($urandom);
         s.lp_a1 = 16'($urandom);
      end
      return s;
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(19))
         14, 15:  return 16'sh7FFF;
         16:      return 16'sh8000;
         17:      return 16'sd0;
         8, 9, 10, 11, 12, 13:
                  return 16'(int'($urandom_range(8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      cfg_type s;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Default settings leave every comb off, so only the dry share remains.
      send_request(1'b0, 16'sh7FFF);
      send_request(1'b1, 16'sh8000);
      send_request(1'b0, 16'sd0);
      send_request(1'b1, -16'sd1);
      drain();

      // Full feedback, full level and full wet with the shortest delay.
      s = '{active_mask: 4'hF, delay_samples: 11'd1, feedback_gain: 16'd32768,
            comb_level: 16'd32768, lp_b0: 16'sh7FFF, lp_b1: 16'sh7FFF,
            lp_a1: 16'sh8000, wet_level: 16'd32768};
      apply_settings(s);
      for (int k = 0; k < 4; k++) begin
         send_request(1'b0, 16'sh7FFF);
         send_request(1'b1, 16'sh8000);
      end
      drain();

      // Zero delay acts as one, and gains above unity act as unity.
      s = '{active_mask: 4'b0101, delay_samples: 11'd0, feedback_gain: 16'hFFFF,
            comb_level: 16'hFFFF, lp_b0: 16'sh8000, lp_b1: 16'sh8000,
            lp_a1: 16'sh7FFF, wet_level: 16'd40000};
      apply_settings(s);
      for (int k = 0; k < 3; k++) begin
         send_request(1'b1, 16'sh7FFF);
         send_request(1'b0, 16'sh8000);
      end
      drain();

      // A delay above the line length is held at the line length.
      s = '{active_mask: 4'hF, delay_samples: 11'h7FF, feedback_gain: 16'd0,
            comb_level: 16'd0, lp_b0: 16'sd0, lp_b1: 16'sd0,
            lp_a1: 16'sd0, wet_level: 16'd0};
      apply_settings(s);
      send_request(1'b0, 16'sh7FFF);
      send_request(1'b1, 16'sh5555);
      send_request(1'b0, 16'shAAAA);
      send_request(1'b1, 16'sh8000);
      drain();

      for (int p = 0; p < RandomPhases; p++) begin
         if (p == RandomPhases / 3) begin
            sender_idle_pct   = 67;
            receiver_idle_pct = 17;
         end else if (p == 2 * RandomPhases / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         apply_settings(random_settings());
         for (int k = 0; k < ItemsPerPhase; k++) begin
            send_request(1'($urandom_range(1)), pick_sample());
         end
         drain();
      end

      repeat (SettleCycles) @(posedge clock);
      if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
